// ----- hdl/gsa_pkg.sv -----
`default_nettype none
package gsa_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int GEN_W     = 16;
  localparam int FOL_W     = 32;
  localparam int FUNC_W    = 3;
  localparam int STAT_W    = 2;
  localparam int TOT_W     = 64;

  localparam int IN_W        = IDX_W + GEN_W + FOL_W;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = STAT_W + IDX_W + GEN_W + 1 + CNT_W + CNT_W + TOT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_ALLOC    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_RELEASE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_VALIDATE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REFRESH  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SWEEP    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DROP_FOL = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  typedef struct packed {
    logic             alive;
    logic             refreshed;
    logic [GEN_W-1:0] gen;
    logic [FOL_W-1:0] fol;
  } slot_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [IDX_W-1:0] push_idx;
  } stk_req_t;

endpackage
`default_nettype wire

// ----- hdl/generational_slot_allocator.sv -----
`default_nettype none
// Channel | Dir | tdata (low bit up)                               | tuser
// s_*     | in  | slot_index, handle_generation, follower_id      | func
// m_*     | out | status, granted_index, granted_generation,      | -
//         |     | handle_ok, live_count, stale_added, stale_total |
// Per transfer: validate/release/refresh pass CHECK, fresh allocate GRANT, allocate
// from the free stack POP then GRANT, full allocate and unused codes go straight to
// DONE; release by follower and sweep walk each slot ever created, none while no slot
// exists, sweep then SUM; the one-read one-write memory is walked one entry a cycle.
// Reset clears counters and the handshake; slots beyond the created count read as
// zero, so no clearing pass is needed.
// A new item is taken while a finished result still waits in the output register.
module generational_slot_allocator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // slot_index, handle_generation, follower_id, zero pad
  input  wire logic [gsa_pkg::IN_TDATA_W-1:0]    s_tdata,
  // func
  input  wire logic [gsa_pkg::FUNC_W-1:0]        s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // status, granted_index, granted_generation, handle_ok, live_count,
  // stale_added, stale_total, zero pad
  output logic [gsa_pkg::OUT_TDATA_W-1:0]        m_tdata
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_POP   = 7'b0000010,
    S_GRANT = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_SUM   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;

  logic [gsa_pkg::IDX_W-1:0]  in_idx;
  logic [gsa_pkg::GEN_W-1:0]  in_gen;
  logic [gsa_pkg::FOL_W-1:0]  in_fol;
  logic                       s_fire;

  logic [gsa_pkg::FUNC_W-1:0] func_q;
  logic [gsa_pkg::GEN_W-1:0]  hgen_q;
  logic [gsa_pkg::FOL_W-1:0]  fol_q;
  logic                       fresh_q;
  logic [gsa_pkg::CNT_W-1:0]  created;
  logic [gsa_pkg::CNT_W-1:0]  alive_total;
  logic [gsa_pkg::TOT_W-1:0]  stale_counter;
  logic [gsa_pkg::CNT_W-1:0]  stale_acc;
  logic [gsa_pkg::STAT_W-1:0] res_status;
  logic [gsa_pkg::IDX_W-1:0]  res_gidx;
  logic [gsa_pkg::GEN_W-1:0]  res_ggen;
  logic                       res_ok;

  gsa_pkg::slot_t             slot_mem [gsa_pkg::NUM_SLOTS];
  gsa_pkg::slot_t             slot_q;
  gsa_pkg::slot_t             slot_rd;
  gsa_pkg::slot_t             wr_data;
  logic [gsa_pkg::IDX_W-1:0]  rd_addr;
  logic [gsa_pkg::IDX_W-1:0]  rd_addr_q;
  logic                       rd_en;
  logic                       wr_en;

  gsa_pkg::stk_req_t          stk_req;
  logic [gsa_pkg::CNT_W-1:0]  stk_depth;
  logic [gsa_pkg::IDX_W-1:0]  stk_top;

  logic                       hit;
  logic                       walk_last;
  logic                       fol_match;

  assign in_idx = s_tdata[gsa_pkg::IDX_W-1:0];
  assign in_gen = s_tdata[gsa_pkg::IDX_W +: gsa_pkg::GEN_W];
  assign in_fol = s_tdata[gsa_pkg::IDX_W + gsa_pkg::GEN_W +: gsa_pkg::FOL_W];

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  // entries never created read as the reset value
  assign slot_rd   = (gsa_pkg::CNT_W'(rd_addr_q) < created) ? slot_q : '0;
  assign hit       = (gsa_pkg::CNT_W'(rd_addr_q) < created) && slot_rd.alive
                     && (slot_rd.gen == hgen_q);
  assign walk_last = (gsa_pkg::CNT_W'(rd_addr_q) + gsa_pkg::CNT_W'(1)) == created;
  assign fol_match = slot_rd.alive && (slot_rd.fol == fol_q);

  gsa_free_stack u_stack (
    .clk   (clk),
    .rst   (rst),
    .req   (stk_req),
    .depth (stk_depth),
    .top   (stk_top)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[rd_addr_q] <= wr_data;
    end
    if (rd_en) begin
      slot_q    <= slot_mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // memory and stack control; writes always land on the entry read the cycle before
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = in_idx;
    wr_en   = 1'b0;
    wr_data = slot_rd;
    stk_req = '0;
    unique case (state)
      S_IDLE: begin
        if (s_fire) begin
          case (s_tuser)
            gsa_pkg::FN_ALLOC: begin
              if (stk_depth != '0) begin
                stk_req.pop = 1'b1;
              end else if (created < gsa_pkg::CNT_W'(gsa_pkg::NUM_SLOTS)) begin
                rd_en   = 1'b1;
                rd_addr = created[gsa_pkg::IDX_W-1:0];
              end
            end
            gsa_pkg::FN_RELEASE, gsa_pkg::FN_VALIDATE, gsa_pkg::FN_REFRESH: begin
              rd_en = 1'b1;
            end
            gsa_pkg::FN_SWEEP, gsa_pkg::FN_DROP_FOL: begin
              rd_en   = (created != '0);
              rd_addr = '0;
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        rd_en   = 1'b1;
        rd_addr = stk_top;
      end
      S_GRANT: begin
        wr_en             = 1'b1;
        wr_data.alive     = 1'b1;
        wr_data.refreshed = 1'b0;
        wr_data.fol       = fol_q;
      end
      S_CHECK: begin
        if (hit && func_q == gsa_pkg::FN_RELEASE) begin
          wr_en            = 1'b1;
          wr_data.alive    = 1'b0;
          wr_data.gen      = slot_rd.gen + gsa_pkg::GEN_W'(1);
          stk_req.push     = 1'b1;
          stk_req.push_idx = rd_addr_q;
        end else if (hit && func_q == gsa_pkg::FN_REFRESH) begin
          wr_en             = 1'b1;
          wr_data.refreshed = 1'b1;
        end
      end
      S_WALK: begin
        rd_en   = !walk_last;
        rd_addr = rd_addr_q + gsa_pkg::IDX_W'(1);
        if (func_q == gsa_pkg::FN_SWEEP) begin
          if (slot_rd.alive && slot_rd.refreshed) begin
            wr_en             = 1'b1;
            wr_data.refreshed = 1'b0;
          end
        end else if (fol_match) begin
          wr_en            = 1'b1;
          wr_data.alive    = 1'b0;
          wr_data.gen      = slot_rd.gen + gsa_pkg::GEN_W'(1);
          stk_req.push     = 1'b1;
          stk_req.push_idx = rd_addr_q;
        end
      end
      S_SUM, S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      created       <= '0;
      alive_total   <= '0;
      stale_counter <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            func_q     <= s_tuser;
            hgen_q     <= in_gen;
            fol_q      <= in_fol;
            res_status <= (s_tuser == gsa_pkg::FN_ALLOC && stk_depth == '0 &&
                           created >= gsa_pkg::CNT_W'(gsa_pkg::NUM_SLOTS)) ?
                          gsa_pkg::STAT_FULL : gsa_pkg::STAT_OK;
            res_gidx   <= '0;
            res_ggen   <= '0;
            res_ok     <= 1'b0;
            stale_acc  <= '0;
            case (s_tuser)
              gsa_pkg::FN_ALLOC: begin
                if (stk_depth != '0) begin
                  fresh_q <= 1'b0;
                  state   <= S_POP;
                end else if (created < gsa_pkg::CNT_W'(gsa_pkg::NUM_SLOTS)) begin
                  fresh_q <= 1'b1;
                  state   <= S_GRANT;
                end else begin
                  state <= S_DONE;
                end
              end
              gsa_pkg::FN_RELEASE, gsa_pkg::FN_VALIDATE, gsa_pkg::FN_REFRESH: begin
                state <= S_CHECK;
              end
              gsa_pkg::FN_SWEEP, gsa_pkg::FN_DROP_FOL: begin
                state <= (created != '0) ? S_WALK : S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_POP: state <= S_GRANT;
        S_GRANT: begin
          if (fresh_q) begin
            created <= created + gsa_pkg::CNT_W'(1);
          end
          alive_total <= alive_total + gsa_pkg::CNT_W'(1);
          res_gidx    <= rd_addr_q;
          res_ggen    <= slot_rd.gen;
          state       <= S_DONE;
        end
        S_CHECK: begin
          res_ok <= hit;
          if (!hit) begin
            res_status <= gsa_pkg::STAT_INVALID;
          end else if (func_q == gsa_pkg::FN_RELEASE && alive_total != '0) begin
            alive_total <= alive_total - gsa_pkg::CNT_W'(1);
          end
          state <= S_DONE;
        end
        S_WALK: begin
          if (func_q == gsa_pkg::FN_SWEEP) begin
            if (slot_rd.alive && !slot_rd.refreshed) begin
              stale_acc <= stale_acc + gsa_pkg::CNT_W'(1);
            end
          end else if (fol_match && alive_total != '0) begin
            alive_total <= alive_total - gsa_pkg::CNT_W'(1);
          end
          if (walk_last) begin
            state <= (func_q == gsa_pkg::FN_SWEEP) ? S_SUM : S_DONE;
          end
        end
        S_SUM: begin
          stale_counter <= stale_counter + gsa_pkg::TOT_W'(stale_acc);
          state         <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= gsa_pkg::OUT_TDATA_W'({stale_counter, stale_acc, alive_total, res_ok,
                                        res_ggen, res_gidx, res_status});
    end
  end

endmodule
`default_nettype wire

// ----- hdl/gsa_free_stack.sv -----
`default_nettype none
module gsa_free_stack (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire gsa_pkg::stk_req_t             req,
  output logic [gsa_pkg::CNT_W-1:0]          depth,
  output logic [gsa_pkg::IDX_W-1:0]          top
);

  logic [gsa_pkg::IDX_W-1:0] mem [gsa_pkg::NUM_SLOTS];
  logic [gsa_pkg::CNT_W-1:0] depth_m1;
  logic                      can_push;

  assign depth_m1 = depth - gsa_pkg::CNT_W'(1);
  assign can_push = depth < gsa_pkg::CNT_W'(gsa_pkg::NUM_SLOTS);

  // LIFO storage, popped entry is registered onto top and appears in the next cycle
  always_ff @(posedge clk) begin
    if (req.push && can_push) begin
      mem[depth[gsa_pkg::IDX_W-1:0]] <= req.push_idx;
    end
    if (req.pop) begin
      top <= mem[depth_m1[gsa_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (req.push && can_push) begin
      depth <= depth + gsa_pkg::CNT_W'(1);
    end else if (req.pop && depth != '0) begin
      depth <= depth_m1;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/gsa_checker.sv -----
`default_nettype none
module gsa_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [gsa_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic [1:0] status;
  logic       ok;
  logic [6:0] live;
  logic [6:0] stale_add;

  assign status    = m_tdata[1:0];
  assign ok        = m_tdata[24];
  assign live      = m_tdata[31:25];
  assign stale_add = m_tdata[38:32];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one item at a time: input closes right after a transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input open right after a transfer");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> status != 2'd3 && (!ok || status == gsa_pkg::STAT_OK))
    else $error("bad status for handle check");

  a_live: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> live <= 7'(gsa_pkg::NUM_SLOTS))
    else $error("live count above slot count");

  a_stale: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> stale_add <= live)
    else $error("more stale slots than live ones");

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
